[src/bba_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the block allocator.
package bba_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int MAX_AMOUNT = 64;
    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
    localparam int ADDR_W     = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int IDX_W      = ADDR_W + BIT_W;
    localparam int CNT_W      = 11;
    localparam int AMT_W      = 7;
    localparam int ACT_W      = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_SET   = 2'd1,
        ACT_QUERY = 2'd2
    } bba_action_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic load;
        logic rd;
        logic commit;
        logic next_word;
        logic fail;
    } bba_cmd_t;

    typedef struct packed {
        logic drop;
        logic is_alloc;
        logic found;
        logic last_word;
        logic out_last;
    } bba_sts_t;

endpackage

[src/bitmap_block_allocator.sv]
// Top level of the first-fit bitmap block allocator.
//
//  channel  | transfer when         | contents
//  ---------+-----------------------+--------------------------------------------------
//  s_ (in)  | s_tvalid & s_tready   | tuser action; tdata block_index, mark_used, amount
//  m_ (out) | m_tvalid & m_tready   | tuser status; tdata result_index, is_used,
//           |                       | free_count; tlast last
//
// One request at a time; s_tready is high only between requests.
// Set and query: steps per request are accept, word read, check and commit, result transfer.
// Allocate: per block handed out, a word read and a check for each 32-block word scanned from
// the word of the previous block, then the result transfer; a run over a full map scans up to
// the last word before the failure result.
// The scan rate is set by the single-port word memory with registered read data.
// Reset clears the per-word valid bits and sets the free count to 1024 at once; no clearing pass.
// A stalled m_tready holds the result and the whole block.
module bitmap_block_allocator import bba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] block_index, [10] mark_used, [17:11] amount
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] result_index, [10] is_used, [21:11] free_count
    output logic        m_tuser,   // [0] status
    output logic        m_tlast
);

    bba_cmd_t         cmd;
    bba_sts_t         sts;
    logic [IDX_W-1:0] result_index;
    logic             is_used;
    logic [CNT_W-1:0] free_count;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_action        (s_tuser),
        .in_block_index   (s_tdata[9:0]),
        .in_mark_used     (s_tdata[10]),
        .in_amount        (s_tdata[17:11]),
        .cmd              (cmd),
        .sts              (sts),
        .out_status       (m_tuser),
        .out_result_index (result_index),
        .out_is_used      (is_used),
        .out_free_count   (free_count),
        .out_last         (m_tlast)
    );

    assign m_tdata = {2'b00, free_count, is_used, result_index};

endmodule

[src/bba_ctrl.sv]
// Control state machine sequencing request intake, bitmap reads, commits and result transfers.
module bba_ctrl import bba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  bba_sts_t sts,
    output bba_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (!sts.drop) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!sts.is_alloc || sts.found) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_SEND;
                end else if (sts.last_word) begin
                    cmd.fail      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_SEND;
                end else begin
                    cmd.next_word = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_SEND: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = sts.out_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[src/bba_datapath.sv]
// Bitmap word memory, free count, lowest-free search and result register.
module bba_datapath import bba_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ACT_W-1:0]  in_action,
    input  logic [IDX_W-1:0]  in_block_index,
    input  logic              in_mark_used,
    input  logic [AMT_W-1:0]  in_amount,
    input  bba_cmd_t          cmd,
    output bba_sts_t          sts,
    output logic              out_status,
    output logic [IDX_W-1:0]  out_result_index,
    output logic              out_is_used,
    output logic [CNT_W-1:0]  out_free_count,
    output logic              out_last
);

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] vld_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;
    logic [ADDR_W-1:0]    rd_addr_reg;

    logic [ACT_W-1:0]     act_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 mark_reg;
    logic [AMT_W-1:0]     rem_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 out_status_reg;
    logic [IDX_W-1:0]     out_index_reg;
    logic                 out_used_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic                 out_last_reg;

    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_W-1:0]    word;
    logic [BIT_W-1:0]     bit_sel;
    logic                 found;
    logic                 is_alloc;
    logic                 old_bit;
    logic [WORD_W-1:0]    wr_data;
    logic                 done;

    assign is_alloc = (act_reg == ACT_ALLOC);
    assign rd_addr  = is_alloc ? ptr_reg : idx_reg[IDX_W-1:BIT_W];
    assign word     = rd_vld_reg ? rd_data_reg : '0;
    assign found    = ~&word;
    assign old_bit  = word[idx_reg[BIT_W-1:0]];
    assign done     = (rem_reg == AMT_W'(1));

    always_comb begin
        bit_sel = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word[i]) begin
                bit_sel = BIT_W'(i);
            end
        end
    end

    always_comb begin
        wr_data = word;
        if (is_alloc) begin
            wr_data[bit_sel] = 1'b1;
        end else begin
            wr_data[idx_reg[BIT_W-1:0]] = mark_reg;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (is_alloc || (act_reg == ACT_SET && old_bit != mark_reg)) begin
            if (is_alloc || mark_reg) begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        sts.drop      = (in_action == ACT_ALLOC && in_amount == '0)
                        || (in_action != ACT_ALLOC && in_action != ACT_SET
                            && in_action != ACT_QUERY);
        sts.is_alloc  = is_alloc;
        sts.found     = found;
        sts.last_word = (ptr_reg == ADDR_W'(NUM_WORDS - 1));
        sts.out_last  = out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.commit && act_reg != ACT_QUERY) begin
            mem[rd_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            cnt_reg <= CNT_W'(NUM_BLOCKS);
        end else if (cmd.commit && act_reg != ACT_QUERY) begin
            vld_reg[rd_addr_reg] <= 1'b1;
            cnt_reg              <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_vld_reg  <= vld_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (cmd.load) begin
            act_reg  <= in_action;
            idx_reg  <= in_block_index;
            mark_reg <= in_mark_used;
            rem_reg  <= (in_amount > AMT_W'(MAX_AMOUNT)) ? AMT_W'(MAX_AMOUNT) : in_amount;
            ptr_reg  <= '0;
        end else if (cmd.next_word) begin
            ptr_reg <= ptr_reg + ADDR_W'(1);
        end else if (cmd.commit && is_alloc) begin
            rem_reg <= rem_reg - AMT_W'(1);
        end
        if (cmd.commit) begin
            out_status_reg <= STATUS_OK;
            out_count_reg  <= cnt_next;
            if (is_alloc) begin
                out_index_reg <= {ptr_reg, bit_sel};
                out_used_reg  <= 1'b1;
                out_last_reg  <= done;
            end else begin
                out_index_reg <= idx_reg;
                out_used_reg  <= (act_reg == ACT_SET) ? mark_reg : old_bit;
                out_last_reg  <= 1'b1;
            end
        end else if (cmd.fail) begin
            out_status_reg <= STATUS_FAIL;
            out_index_reg  <= '0;
            out_used_reg   <= 1'b0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_status       = out_status_reg;
    assign out_result_index = out_index_reg;
    assign out_is_used      = out_used_reg;
    assign out_free_count   = out_count_reg;
    assign out_last         = out_last_reg;

endmodule
